FILE: rtl/cpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

  // Field and internal widths
  localparam int RadiusBits = 12;
  localparam int ScreenBits = 12;
  localparam int CoordW     = RadiusBits + 1;   // x and y, signed
  localparam int DecW       = RadiusBits + 3;   // decision variable, signed
  localparam int ScrW       = ScreenBits + 1;   // screen size registers
  localparam int CentreW    = 14;
  localparam int PixW       = 15;
  localparam int ColourW    = 32;
  localparam int CfgIdxW    = 2;
  localparam int StepPts    = 8;
  localparam int PtIdxW     = $clog2(StepPts);

  // Operation codes carried in the input tuser
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;

  // Reset values of the screen size
  localparam logic [ScrW-1:0] ScreenWidthRst  = 13'd640;
  localparam logic [ScrW-1:0] ScreenHeightRst = 13'd480;

  // One loop iteration handed from the front to the back
  typedef struct packed {
    logic signed [CentreW-1:0] cx;
    logic signed [CentreW-1:0] cy;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic [ColourW-1:0]        colour;
    logic                      active;
  } step_job_t;

  // Status of the back part seen by the top level
  typedef struct packed {
    logic busy;
    logic job_done;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: rtl/cpg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cpg_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                op_i,
  input  wire logic signed [cpg_pkg::CentreW-1:0]  centre_col_i,
  input  wire logic signed [cpg_pkg::CentreW-1:0]  centre_row_i,
  input  wire logic [cpg_pkg::RadiusBits-1:0]      radius_i,
  input  wire logic [cpg_pkg::ColourW-1:0]         colour_i,
  input  wire logic                                q_full_i,
  output logic                                     push_o,
  output cpg_pkg::step_job_t                       job_o
);

  localparam int ExtW = cpg_pkg::DecW + 1;

  logic signed [cpg_pkg::CentreW-1:0]    cx_q, cy_q;
  logic [cpg_pkg::ColourW-1:0]           colour_q;
  logic [cpg_pkg::RadiusBits-1:0]        radius_q;
  logic signed [cpg_pkg::CoordW-1:0]     x_q, x_d, y_q, y_d;
  logic signed [cpg_pkg::DecW-1:0]       d_q, d_d;
  logic signed [ExtW-1:0]                d_e, x_e, y_e, r_e;
  logic                                  active;
  logic                                  accept;

  // Steps wait for room in the queue; starts need none but share the gate
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (op_i == cpg_pkg::OpStep);
  assign active     = (y_q >= x_q);

  // Snapshot of the current iteration
  assign job_o.cx     = cx_q;
  assign job_o.cy     = cy_q;
  assign job_o.x      = x_q;
  assign job_o.y      = y_q;
  assign job_o.colour = colour_q;
  assign job_o.active = active;

  assign d_e = ExtW'(d_q);
  assign x_e = ExtW'(x_q);
  assign y_e = ExtW'(y_q);
  assign r_e = ExtW'($signed({1'b0, radius_q}));

  // Decision rule: step right, step down, or step diagonally
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    d_d = d_q;
    if (d_e >= (x_e <<< 1)) begin
      d_d = cpg_pkg::DecW'(d_e - (x_e <<< 1) - ExtW'(1));
      x_d = x_q + cpg_pkg::CoordW'(1);
    end else if (d_e <= ((r_e - y_e) <<< 1)) begin
      d_d = cpg_pkg::DecW'(d_e + (y_e <<< 1) - ExtW'(1));
      y_d = y_q - cpg_pkg::CoordW'(1);
    end else begin
      d_d = cpg_pkg::DecW'(d_e + ((y_e - x_e - ExtW'(1)) <<< 1));
      y_d = y_q - cpg_pkg::CoordW'(1);
      x_d = x_q + cpg_pkg::CoordW'(1);
    end
  end

  // Load a new circle on start, advance the loop on an active step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      colour_q <= '0;
      radius_q <= '0;
      x_q      <= '0;
      y_q      <= '1;
      d_q      <= '0;
    end else if (accept) begin
      if (op_i == cpg_pkg::OpStart) begin
        cx_q     <= centre_col_i;
        cy_q     <= centre_row_i;
        colour_q <= colour_i;
        radius_q <= radius_i;
        x_q      <= '0;
        y_q      <= $signed({1'b0, radius_i});
        d_q      <= cpg_pkg::DecW'($signed({1'b0, radius_i})) - cpg_pkg::DecW'(1);
      end else if (active) begin
        x_q <= x_d;
        y_q <= y_d;
        d_q <= d_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cpg_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire cpg_pkg::step_job_t  job_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output cpg_pkg::step_job_t       job_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cpg_pkg::step_job_t   slot_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cpg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [cpg_pkg::ScrW-1:0]      screen_width_i,
  input  wire logic [cpg_pkg::ScrW-1:0]      screen_height_i,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire cpg_pkg::step_job_t            job_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [cpg_pkg::PixW-1:0]    pixel_col_o,
  output logic signed [cpg_pkg::PixW-1:0]    pixel_row_o,
  output logic [cpg_pkg::ColourW-1:0]        pixel_colour_o,
  output logic                               visible_o,
  output logic                               finished_o,
  output logic                               last_o,
  output cpg_pkg::back_stat_t                stat_o
);

  localparam logic [cpg_pkg::PtIdxW-1:0] LastPt = cpg_pkg::PtIdxW'(cpg_pkg::StepPts - 1);

  cpg_pkg::step_job_t                 job_q;
  logic                               busy_q;
  logic [cpg_pkg::PtIdxW-1:0]         pt_q;
  logic                               out_free;
  logic                               emit;
  logic                               job_end;
  logic signed [cpg_pkg::CoordW-1:0]  off_a, off_b;
  logic signed [cpg_pkg::PixW-1:0]    col_pt, row_pt;
  logic                               vis;

  logic                               valid_q;
  logic signed [cpg_pkg::PixW-1:0]    col_q, row_q;
  logic [cpg_pkg::ColourW-1:0]        colour_q;
  logic                               vis_q, fin_q, last_q;

  assign out_free = !valid_q || out_ready_i;
  assign emit     = busy_q && out_free;
  assign job_end  = emit && (pt_q == LastPt);
  assign q_pop_o  = q_valid_i && (!busy_q || job_end);

  assign stat_o.busy     = busy_q;
  assign stat_o.job_done = job_end;

  // Octant point: bit 0 swaps x and y, bit 1 mirrors the column, bit 2 the row
  assign off_a  = pt_q[0] ? job_q.y : job_q.x;
  assign off_b  = pt_q[0] ? job_q.x : job_q.y;
  assign col_pt = cpg_pkg::PixW'(job_q.cx) +
                  (pt_q[1] ? -cpg_pkg::PixW'(off_a) : cpg_pkg::PixW'(off_a));
  assign row_pt = cpg_pkg::PixW'(job_q.cy) +
                  (pt_q[2] ? -cpg_pkg::PixW'(off_b) : cpg_pkg::PixW'(off_b));
  assign vis    = job_q.active &&
                  !col_pt[cpg_pkg::PixW-1] &&
                  (col_pt[cpg_pkg::PixW-2:0] < {1'b0, screen_width_i}) &&
                  !row_pt[cpg_pkg::PixW-1] &&
                  (row_pt[cpg_pkg::PixW-2:0] < {1'b0, screen_height_i});

  // Hold the current job and walk its eight points
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pt_q   <= '0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        pt_q   <= '0;
      end else begin
        if (job_end) begin
          busy_q <= 1'b0;
        end
        if (emit) begin
          pt_q <= pt_q + cpg_pkg::PtIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= job_i;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= emit;
    end
  end

  // Output register: beat payload, zeroed once the loop has ended
  always_ff @(posedge clk_i) begin
    if (emit) begin
      col_q    <= job_q.active ? col_pt : '0;
      row_q    <= job_q.active ? row_pt : '0;
      colour_q <= job_q.active ? job_q.colour : '0;
      vis_q    <= vis;
      fin_q    <= !job_q.active;
      last_q   <= (pt_q == LastPt);
    end
  end

  assign out_valid_o    = valid_q;
  assign pixel_col_o    = col_q;
  assign pixel_row_o    = row_q;
  assign pixel_colour_o = colour_q;
  assign visible_o      = vis_q;
  assign finished_o     = fin_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

FILE: rtl/circle_pixel_generator.sv
// Circle rasteriser (Andres decision rule), eight symmetric points per step.
//
// Input stream: tuser carries the operation. A start beat loads centre,
// radius and colour and produces nothing; a step beat runs one loop
// iteration and produces eight output beats, tlast on the eighth. Once the
// loop has ended a step gives eight beats with finished set and zero data.
// Output tuser flags each point visible when it lies on the screen.
// Configuration channel: index 0 screen width, index 1 screen height; write
// only while no step is outstanding. Other indexes are ignored.
//
// Latency: a step passes the job queue, the back part's job register and
// the output register. Throughput: one point per cycle unless the
// receiver stalls, set by the back part's single output port. A two-entry
// job queue lets the front take more starts and steps while the back emits.
// Reset: screen 640 by 480, no circle loaded (the loop reads as ended).
// When the receiver stalls, the output beat holds, the back stops, and
// input tready drops once the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module circle_pixel_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [71:0]                       s_axis_tdata,  // centre_col, centre_row, radius, pen_colour
  input  wire logic                              s_axis_tuser,  // operation
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [63:0]                            m_axis_tdata,  // pixel_col, pixel_row, pixel_colour, pad
  output logic [1:0]                             m_axis_tuser,  // visible, finished
  output logic                                   m_axis_tlast,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [cpg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [cpg_pkg::ScrW-1:0]          cfg_data_i
);

  logic [cpg_pkg::ScrW-1:0]            screen_width_q, screen_height_q;
  logic                                q_full, q_valid, q_push, q_pop;
  cpg_pkg::step_job_t                  job_in, job_out;
  cpg_pkg::back_stat_t                 back_stat;
  logic signed [cpg_pkg::PixW-1:0]     pixel_col, pixel_row;
  logic [cpg_pkg::ColourW-1:0]         pixel_colour;
  logic                                visible, finished;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= cpg_pkg::ScreenWidthRst;
      screen_height_q <= cpg_pkg::ScreenHeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cpg_pkg::CfgScreenWidth:  screen_width_q  <= cfg_data_i;
        cpg_pkg::CfgScreenHeight: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cpg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .centre_col_i (s_axis_tdata[13:0]),
    .centre_row_i (s_axis_tdata[27:14]),
    .radius_i     (s_axis_tdata[39:28]),
    .colour_i     (s_axis_tdata[71:40]),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .job_o        (job_in)
  );

  cpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (job_out)
  );

  cpg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .job_i           (job_out),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pixel_col_o     (pixel_col),
    .pixel_row_o     (pixel_row),
    .pixel_colour_o  (pixel_colour),
    .visible_o       (visible),
    .finished_o      (finished),
    .last_o          (m_axis_tlast),
    .stat_o          (back_stat)
  );

  assign m_axis_tdata = {2'b00, pixel_colour, pixel_row, pixel_col};
  assign m_axis_tuser = {finished, visible};

  // A full queue means the back part must be working through a job
  a_full_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> back_stat.busy)
    else $error("queue full while back part idle");

  // A point past the end of the loop is never visible
  a_finished_invisible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("finished point flagged visible");

  // Points after the loop has ended carry zero data
  a_finished_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0))
    else $error("finished point carries data");

  // The eighth point of a job is the one marked last
  a_last_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.job_done |=> m_axis_tvalid && m_axis_tlast)
    else $error("job end not marked last");

endmodule

`default_nettype wire

FILE: tb/circle_pixel_generator_tb.sv
`timescale 1ns / 1ps

module circle_pixel_generator_tb;

  localparam int LimitCycles  = 200000;
  localparam int RandomItems  = 390;
  localparam int SettleCycles = 12;
  localparam int NoLimit      = 100000;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [cpg_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [cpg_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    logic signed [cpg_pkg::PixW-1:0] col;
    logic signed [cpg_pkg::PixW-1:0] row;
    logic [cpg_pkg::ColourW-1:0]     colour;
    logic                            visible;
    logic                            finished;
    logic                            last;
  } point_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [71:0]                 s_axis_tdata;
  logic                        s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [63:0]                 m_axis_tdata;
  logic [1:0]                  m_axis_tuser;
  logic                        m_axis_tlast;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [cpg_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [cpg_pkg::ScrW-1:0]    cfg_data_i;

  // Predicted state of the rasteriser
  logic signed [cpg_pkg::CentreW-1:0] ctr_col;
  logic signed [cpg_pkg::CentreW-1:0] ctr_row;
  logic [cpg_pkg::ColourW-1:0]        pen;
  logic [cpg_pkg::RadiusBits-1:0]     rad;
  int                                 loop_x;
  int                                 loop_y;
  int                                 loop_d;
  logic [cpg_pkg::ScrW-1:0]           scr_w;
  logic [cpg_pkg::ScrW-1:0]           scr_h;

  point_t pending_points[$];
  bit     quiet = 1'b0;
  int     mismatches = 0;
  int     items_sent = 0;
  int     starts_sent = 0;
  int     steps_sent = 0;
  int     points_checked = 0;
  int     ended_points = 0;
  int     settings_tried = 0;
  longint cycles = 0;

  circle_pixel_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Latch centre, radius and colour; restart the loop at the top of the circle
  function automatic void load_circle(logic [71:0] fields);
    ctr_col = $signed(fields[13:0]);
    ctr_row = $signed(fields[27:14]);
    rad     = fields[39:28];
    pen     = fields[71:40];
    loop_x  = 0;
    loop_y  = int'(rad);
    loop_d  = int'(rad) - 1;
  endfunction

  // Queue the eight mirrored points of the current iteration, then advance
  function automatic void plot_octants();
    int     dx [cpg_pkg::StepPts];
    int     dy [cpg_pkg::StepPts];
    int     c;
    int     r;
    bit     active;
    point_t p;
    active = loop_y >= loop_x;
    dx = '{loop_x, loop_y, -loop_x, -loop_y, loop_x, loop_y, -loop_x, -loop_y};
    dy = '{loop_y, loop_x, loop_y, loop_x, -loop_y, -loop_x, -loop_y, -loop_x};
    for (int k = 0; k < cpg_pkg::StepPts; k++) begin
      c = int'(ctr_col) + dx[k];
      r = int'(ctr_row) + dy[k];
      p.col      = active ? c[cpg_pkg::PixW-1:0] : '0;
      p.row      = active ? r[cpg_pkg::PixW-1:0] : '0;
      p.colour   = active ? pen : '0;
      p.visible  = active && c >= 0 && c < int'(scr_w) && r >= 0 && r < int'(scr_h);
      p.finished = !active;
      p.last     = (k == cpg_pkg::StepPts - 1);
      pending_points.push_back(p);
      if (!active) ended_points++;
    end
    if (active) begin
      if (loop_d >= 2 * loop_x) begin
        loop_d = loop_d - 2 * loop_x - 1;
        loop_x++;
      end else if (loop_d <= 2 * (int'(rad) - loop_y)) begin
        loop_d = loop_d + 2 * loop_y - 1;
        loop_y--;
      end else begin
        loop_d = loop_d + 2 * (loop_y - loop_x - 1);
        loop_y--;
        loop_x++;
      end
    end
  endfunction

  // Present one beat, hold it until taken, then update the prediction
  task automatic send_item(logic op, logic [71:0] fields);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= fields;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == cpg_pkg::OpStart) begin
      load_circle(fields);
      starts_sent++;
    end else begin
      plot_octants();
      steps_sent++;
    end
    items_sent++;
  endtask

  // Step content is ignored by the block, so fill it with noise
  task automatic send_step();
    send_item(cpg_pkg::OpStep, {$urandom(), $urandom(), 8'($urandom())});
  endtask

  // Start a circle, step it up to max_steps or its end, then step extra times
  task automatic draw_circle(int col, int row, int r, logic [31:0] colour,
                             int max_steps, int extra);
    int n;
    send_item(cpg_pkg::OpStart, {colour, r[11:0], row[13:0], col[13:0]});
    n = 0;
    while (loop_y >= loop_x && n < max_steps) begin
      send_step();
      n++;
    end
    repeat (extra) send_step();
  endtask

  // Drop valid and let every pending point drain before touching registers
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [cpg_pkg::CfgIdxW-1:0] idx,
                           logic [cpg_pkg::ScrW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == cpg_pkg::CfgScreenWidth) scr_w = value;
    else if (idx == cpg_pkg::CfgScreenHeight) scr_h = value;
  endtask

  task automatic set_screen(int w, int h, bit spare);
    wait_drained();
    write_reg(cpg_pkg::CfgScreenWidth, w[cpg_pkg::ScrW-1:0]);
    if (spare) begin
      write_reg(CfgSpareLo, cpg_pkg::ScrW'($urandom_range(8191)));
      write_reg(CfgSpareHi, cpg_pkg::ScrW'($urandom_range(8191)));
    end
    write_reg(cpg_pkg::CfgScreenHeight, h[cpg_pkg::ScrW-1:0]);
    cfg_valid_i <= 1'b0;
    settings_tried++;
  endtask

  // Nothing loaded after reset: steps must report the loop as ended
  task automatic test_ended_loop();
    send_step();
    send_step();
  endtask

  task automatic test_directed_circles();
    // radius zero: centre eight times, then the loop ends
    draw_circle(0, 0, 0, 32'hFFFF_FFFF, NoLimit, 1);
    // extreme centres with the largest radius, far off screen
    draw_circle(-8192, 8191, 4095, 32'h0000_0000, 2, 0);
    draw_circle(8191, -8192, 4095, 32'hA5C3_0F96, 2, 0);
    // screen corners and centre with the reset size
    draw_circle(0, 0, 3, $urandom(), NoLimit, 1);
    draw_circle(639, 479, 1, $urandom(), NoLimit, 0);
    draw_circle(320, 240, 6, $urandom(), NoLimit, 0);
  endtask

  task automatic test_screen_settings();
    set_screen(4096, 4096, 1'b0);
    draw_circle(4095, 0, 2, $urandom(), NoLimit, 0);
    draw_circle(2000, 4095, 5, $urandom(), NoLimit, 0);
    set_screen(1, 1, 1'b1);
    draw_circle(0, 0, 1, $urandom(), NoLimit, 0);
    draw_circle(0, 0, 0, $urandom(), NoLimit, 0);
    // zero size: nothing may be visible
    set_screen(0, 0, 1'b0);
    draw_circle(0, 0, 2, $urandom(), NoLimit, 1);
    set_screen(8191, 8191, 1'b1);
    draw_circle(8000, 100, 300, $urandom(), 4, 0);
    set_screen(640, 480, 1'b1);
    draw_circle(630, 10, 12, $urandom(), NoLimit, 0);
  endtask

  task automatic test_random_circles();
    int          first;
    int          pick;
    int          w;
    int          h;
    int          col;
    int          row;
    int          steps;
    logic [31:0] colour;
    first = items_sent;
    while (items_sent - first < RandomItems) begin
      // a long stretch with neither side idling
      quiet = (items_sent - first) >= 150 && (items_sent - first) < 260;
      if ($urandom_range(99) < 6) begin
        pick = $urandom_range(9);
        w = pick == 0 ? 0 : pick == 1 ? $urandom_range(8191) : $urandom_range(1, 4096);
        pick = $urandom_range(9);
        h = pick == 0 ? 0 : pick == 1 ? $urandom_range(8191) : $urandom_range(1, 4096);
        set_screen(w, h, $urandom_range(3) == 0);
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        // well-formed circle around the screen edges
        col = $urandom_range(0, int'(scr_w) + 80) - 40;
        row = $urandom_range(0, int'(scr_h) + 80) - 40;
        steps = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : NoLimit;
        colour = $urandom();
        draw_circle(col, row, $urandom_range(40), colour, steps, $urandom_range(2));
      end else if (pick < 90) begin
        // anywhere, any radius, cut short
        col = $urandom_range(16383) - 8192;
        row = $urandom_range(16383) - 8192;
        draw_circle(col, row, $urandom_range(4095), $urandom(), $urandom_range(1, 6), 0);
      end else begin
        // stray beat
        send_item(1'($urandom_range(1)), {$urandom(), $urandom(), 8'($urandom())});
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) m_axis_tready <= quiet || ($urandom_range(99) >= 7);

  // Compare each accepted pixel beat with the oldest pending point
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        $error("pixel beat with no point pending");
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (m_axis_tdata[14:0] !== want.col) begin
          $error("pixel_col: expected %0d, got %0d", want.col, $signed(m_axis_tdata[14:0]));
          mismatches++;
        end
        if (m_axis_tdata[29:15] !== want.row) begin
          $error("pixel_row: expected %0d, got %0d", want.row, $signed(m_axis_tdata[29:15]));
          mismatches++;
        end
        if (m_axis_tdata[61:30] !== want.colour) begin
          $error("pixel_colour: expected %h, got %h", want.colour, m_axis_tdata[61:30]);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cpg_pkg::OpStart;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = cpg_pkg::CfgScreenWidth;
    cfg_data_i    = '0;
    scr_w         = cpg_pkg::ScreenWidthRst;
    scr_h         = cpg_pkg::ScreenHeightRst;
    ctr_col       = '0;
    ctr_row       = '0;
    pen           = '0;
    rad           = '0;
    loop_x        = 0;
    loop_y        = -1;
    loop_d        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ended_loop();
    test_directed_circles();
    test_screen_settings();
    test_random_circles();
    wait_drained();

    $display("Sent %0d beats (%0d circle starts, %0d steps) over %0d screen settings.",
             items_sent, starts_sent, steps_sent, settings_tried);
    $display("Checked %0d pixel beats, %0d of them after the loop had ended.",
             points_checked, ended_points);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cpg_pkg.sv
rtl/cpg_front.sv
rtl/cpg_queue.sv
rtl/cpg_back.sv
rtl/circle_pixel_generator.sv
tb/circle_pixel_generator_tb.sv
